// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on a given clock, off while the given reset is low
`define ASSERT_AT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// property on the house clock and reset
`define ASSERT_STD(lbl, prop, msg) \
	`ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

// ===== hdl/lsfp_pkg.sv =====
// constants and types of the serial range-finder frame parser
// no dependencies
package lsfp_pkg;

	localparam int unsigned FRAME_LEN   = 9;
	localparam int unsigned FLUSH_COUNT = 18;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned DIST_W      = 13;
	localparam int unsigned STREN_W     = 16;
	localparam int unsigned QUAL_W      = 8;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h59;

	// x / 10 for 16-bit x as (x * 0xCCCD) >> 19
	localparam logic [16:0] DIV10_MUL   = 17'd52429;
	localparam int unsigned DIV10_SHIFT = 19;

	typedef struct packed {
		logic               frame_valid;
		logic [DIST_W-1:0]  range_cm;
		logic [STREN_W-1:0] strength;
		logic [QUAL_W-1:0]  quality;
		logic               checksum_error;
		logic               overflow_flush;
	} res_t;

endpackage

// ===== hdl/lsfp_byte_if.sv =====
// byte channel: valid/ready handshake carrying one received serial byte
// depends on lsfp_pkg
interface lsfp_byte_if;
	logic                         valid;
	logic                         ready;
	logic [lsfp_pkg::BYTE_W-1:0]  data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hdl/lsfp_result_if.sv =====
// result channel: valid/ready handshake carrying one parser result
// depends on lsfp_pkg
interface lsfp_result_if;
	logic                          valid;
	logic                          ready;
	logic                          frame_valid;
	logic [lsfp_pkg::DIST_W-1:0]   range_cm;
	logic [lsfp_pkg::STREN_W-1:0]  strength;
	logic [lsfp_pkg::QUAL_W-1:0]   quality;
	logic                          checksum_error;
	logic                          overflow_flush;

	modport source (output valid, output frame_valid, output range_cm, output strength,
		output quality, output checksum_error, output overflow_flush, input ready);
	modport sink   (input valid, input frame_valid, input range_cm, input strength,
		input quality, input checksum_error, input overflow_flush, output ready);
endinterface

// ===== hdl/lidar_serial_frame_parser.sv =====
// serial range-finder frame parser, top level
// depends on lsfp_pkg, lsfp_byte_if, lsfp_result_if
//
// Usage:
//   in_ch carries one received serial byte per beat. The block keeps the last
//   nine bytes and a count of bytes since the last resync. When nine or more
//   are held and the newest nine start with two sync bytes, the checksum is
//   tested: a good frame gives distance (cm), strength and quality, a bad one
//   a checksum error. Eighteen bytes without a good frame give an overflow flush.
//   out_ch carries one result beat for each byte that causes one; quiet bytes
//   give nothing.
//   Output: each result is registered in the output register or the skid register.
//   Throughput: one byte per cycle while in_ch is ready; the window shift, the
//   8-byte sum and the divide-by-ten multiply all sit between the byte beat and
//   the output register.
//   Stall: a two-entry output stage (output register plus skid register)
//   keeps in_ch ready while one result waits; in_ch drops ready only while
//   both entries are full.
//   Reset: arst_n clears the window, the count and both output entries.
module lidar_serial_frame_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	lsfp_byte_if.sink            in_ch,
	lsfp_result_if.source        out_ch
);

	logic [lsfp_pkg::BYTE_W-1:0]  win_q [lsfp_pkg::FRAME_LEN];
	logic [lsfp_pkg::BYTE_W-1:0]  win_d [lsfp_pkg::FRAME_LEN];
	logic [lsfp_pkg::COUNT_W-1:0] cnt_q;
	logic [lsfp_pkg::COUNT_W-1:0] cnt_inc;
	logic [lsfp_pkg::COUNT_W-1:0] cnt_d;
	logic [lsfp_pkg::BYTE_W-1:0]  sum;
	logic [15:0]                  raw_mm;
	logic [32:0]                  prod;
	logic                         hdr_ok;
	logic                         good;
	logic                         cks_err;
	logic                         flush;
	logic                         has_res;
	logic                         in_fire;
	lsfp_pkg::res_t               res;

	logic                         out_v_q;
	lsfp_pkg::res_t               out_q;
	logic                         skid_v_q;
	lsfp_pkg::res_t               skid_q;

	assign in_fire     = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !skid_v_q;

	// shifted window with the new byte at the newest end
	always_comb begin
		for (int i = 0; i < lsfp_pkg::FRAME_LEN - 1; i++) begin
			win_d[i] = win_q[i+1];
		end
		win_d[lsfp_pkg::FRAME_LEN-1] = in_ch.data_byte;
	end

	// checksum over the first eight frame bytes, kept to 8 bits
	always_comb begin
		sum = '0;
		for (int i = 0; i < lsfp_pkg::FRAME_LEN - 1; i++) begin
			sum = sum + win_d[i];
		end
	end

	// frame detection and count update
	always_comb begin
		cnt_inc = cnt_q + lsfp_pkg::COUNT_W'(1);
		hdr_ok  = (cnt_inc >= lsfp_pkg::COUNT_W'(lsfp_pkg::FRAME_LEN))
			&& (win_d[0] == lsfp_pkg::SYNC_BYTE) && (win_d[1] == lsfp_pkg::SYNC_BYTE);
		good    = hdr_ok && (sum == win_d[lsfp_pkg::FRAME_LEN-1]);
		cks_err = hdr_ok && !good;
		cnt_d   = good ? '0 : cnt_inc;
		flush   = (cnt_d >= lsfp_pkg::COUNT_W'(lsfp_pkg::FLUSH_COUNT));
		if (flush) begin
			cnt_d = '0;
		end
		has_res = good || cks_err || flush;
	end

	// distance in cm: millimetre field times reciprocal of ten
	assign raw_mm = {win_d[3], win_d[2]};
	assign prod   = {17'd0, raw_mm} * {16'd0, lsfp_pkg::DIV10_MUL};

	always_comb begin
		res.frame_valid    = good;
		res.range_cm       = good ? prod[lsfp_pkg::DIV10_SHIFT +: lsfp_pkg::DIST_W] : '0;
		res.strength       = good ? {win_d[5], win_d[4]} : '0;
		res.quality        = good ? win_d[7] : '0;
		res.checksum_error = cks_err;
		res.overflow_flush = flush;
	end

	// window and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < lsfp_pkg::FRAME_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (in_fire) begin
			cnt_q <= cnt_d;
			win_q <= win_d;
		end
	end

	// output register with skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ch.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire && has_res;
			end
		end else if (in_fire && has_res) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload of the two entries
	always_ff @(posedge clk) begin
		if (!out_v_q || out_ch.ready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (in_fire && has_res) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.frame_valid    = out_q.frame_valid;
	assign out_ch.range_cm       = out_q.range_cm;
	assign out_ch.strength       = out_q.strength;
	assign out_ch.quality        = out_q.quality;
	assign out_ch.checksum_error = out_q.checksum_error;
	assign out_ch.overflow_flush = out_q.overflow_flush;

endmodule

// ===== hdl/lsfp_checker.sv =====
// port-level checks of the serial range-finder frame parser, bound to the top
// depends on lsfp_pkg and assert_macros.svh
`include "assert_macros.svh"

module lsfp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          frame_valid,
	input logic [lsfp_pkg::DIST_W-1:0]   range_cm,
	input logic [lsfp_pkg::STREN_W-1:0]  strength,
	input logic [lsfp_pkg::QUAL_W-1:0]   quality,
	input logic                          checksum_error,
	input logic                          overflow_flush
);

	lsfp_pkg::res_t beat;

	// whole result beat as one vector
	assign beat = {frame_valid, range_cm, strength, quality, checksum_error, overflow_flush};

	// stalled result beat holds
	`ASSERT_STD(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(beat), "beat changed")

	// every result beat reports something
	`ASSERT_STD(a_not_empty, out_valid |-> frame_valid || checksum_error || overflow_flush, "empty beat")

	// a good frame excludes checksum error and overflow
	`ASSERT_STD(a_good_alone, out_valid && frame_valid |-> !checksum_error && !overflow_flush, "good+err")

	// frame fields are zero without a good frame
	`ASSERT_STD(a_fields_zero, out_valid && !frame_valid |-> {range_cm, strength, quality} == '0, "fields")

	// distance stays in range
	`ASSERT_STD(a_range_max, out_valid |-> range_cm <= 13'd6553, "distance out of range")

endmodule

bind lidar_serial_frame_parser lsfp_checker u_lsfp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.frame_valid    (out_ch.frame_valid),
	.range_cm       (out_ch.range_cm),
	.strength       (out_ch.strength),
	.quality        (out_ch.quality),
	.checksum_error (out_ch.checksum_error),
	.overflow_flush (out_ch.overflow_flush)
);

// ===== tb/tb_lidar_serial_frame_parser.sv =====
// testbench of lidar_serial_frame_parser: directed frames, then random frame traffic
// depends on lsfp_pkg, lsfp_byte_if, lsfp_result_if and the parser top level
`timescale 1ns / 100ps

module tb_lidar_serial_frame_parser;

	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned RANDOM_BYTES = 395;
	localparam int unsigned DRAIN_CYCLES = 4;

	typedef logic [lsfp_pkg::BYTE_W-1:0] byte_t;
	typedef logic [lsfp_pkg::DIST_W-1:0] range_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_BLOCKS
	} rx_mode_t;

	logic clk;
	logic arst_n;

	lsfp_byte_if   byte_ch();
	lsfp_result_if res_ch();

	lidar_serial_frame_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (byte_ch),
		.out_ch (res_ch)
	);

	// shadow copy of the frame window and the resync count
	byte_t                        shadow_win [lsfp_pkg::FRAME_LEN];
	logic [lsfp_pkg::COUNT_W-1:0] shadow_held;

	lsfp_pkg::res_t pending_q [$];
	lsfp_pkg::res_t got_res;
	lsfp_pkg::res_t want_res;
	int unsigned    err_cnt;
	int unsigned    cycle_cnt;
	int unsigned    burst_left;
	int unsigned    bytes_sent;
	rx_mode_t       rx_mode;
	logic [5:0]     rx_phase;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shift one byte into the shadow window and work out the result it causes
	function automatic bit parse_byte(input byte_t b, output lsfp_pkg::res_t r);
		byte_t       sum8;
		logic [15:0] raw;
		int          i;
		r = '0;
		for (i = 0; i < lsfp_pkg::FRAME_LEN - 1; i++)
			shadow_win[i] = shadow_win[i + 1];
		shadow_win[lsfp_pkg::FRAME_LEN - 1] = b;
		shadow_held = shadow_held + 1'b1;
		if (shadow_held >= lsfp_pkg::FRAME_LEN && shadow_win[0] == lsfp_pkg::SYNC_BYTE
				&& shadow_win[1] == lsfp_pkg::SYNC_BYTE) begin
			sum8 = '0;
			for (i = 0; i < lsfp_pkg::FRAME_LEN - 1; i++)
				sum8 = sum8 + shadow_win[i];
			if (sum8 == shadow_win[lsfp_pkg::FRAME_LEN - 1]) begin
				raw = {shadow_win[3], shadow_win[2]};
				r.frame_valid = 1'b1;
				r.range_cm    = range_t'(raw / 16'd10);
				r.strength    = {shadow_win[5], shadow_win[4]};
				r.quality     = shadow_win[7];
				shadow_held   = '0;
			end else begin
				r.checksum_error = 1'b1;
			end
		end
		if (shadow_held >= lsfp_pkg::FLUSH_COUNT) begin
			shadow_held      = '0;
			r.overflow_flush = 1'b1;
		end
		return r.frame_valid | r.checksum_error | r.overflow_flush;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
		err_cnt++;
	endtask

	// one byte beat, with bursts and random gaps on the sending side
	task automatic send_byte(input byte_t b);
		lsfp_pkg::res_t want;
		int unsigned    gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
			burst_left = $urandom_range(1, 20);
			if (gap != 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		if (parse_byte(b, want))
			pending_q.push_back(want);
		burst_left--;
		bytes_sent++;
	endtask

	// two sync bytes, six body bytes, then a good or a corrupted checksum
	task automatic send_frame(input byte_t b2, b3, b4, b5, b6, b7,
			input bit good, input byte_t corrupt);
		byte_t cks;
		cks = lsfp_pkg::SYNC_BYTE + lsfp_pkg::SYNC_BYTE + b2 + b3 + b4 + b5 + b6 + b7;
		if (!good)
			cks = cks + corrupt;
		send_byte(lsfp_pkg::SYNC_BYTE);
		send_byte(lsfp_pkg::SYNC_BYTE);
		send_byte(b2);
		send_byte(b3);
		send_byte(b4);
		send_byte(b5);
		send_byte(b6);
		send_byte(b7);
		send_byte(cks);
	endtask

	// largest and smallest field values; reserved byte nonzero in the second frame
	task automatic test_field_extremes();
		send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1, 8'h00);
		send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h00, 1'b1, 8'h00);
	endtask

	// checksum error on byte 9, then another one on byte 18 along with the flush
	task automatic test_error_at_overflow();
		send_frame(8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 1'b0, 8'h01);
		send_frame(8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 1'b0, 8'h01);
	endtask

	// good frame on byte 18 clears the count without a flush; then one byte that
	// would close a good frame if the count had not been cleared
	task automatic test_frame_at_overflow_and_resync();
		send_frame(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 1'b0, 8'h01);
		send_frame(lsfp_pkg::SYNC_BYTE, lsfp_pkg::SYNC_BYTE, lsfp_pkg::SYNC_BYTE,
			lsfp_pkg::SYNC_BYTE, lsfp_pkg::SYNC_BYTE, lsfp_pkg::SYNC_BYTE, 1'b1, 8'h00);
		// seven sync bytes plus the old checksum 0xC8 sum to 0x37
		send_byte(8'h37);
	endtask

	// mostly well-formed frames, some with random junk before them, some plain noise
	task automatic test_random_traffic();
		int unsigned start_cnt;
		int unsigned n;
		int unsigned k;
		start_cnt = bytes_sent;
		while (bytes_sent - start_cnt < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) < 2) begin
				n = $urandom_range(1, 20);
				for (k = 0; k < n; k++)
					send_byte(($urandom_range(0, 3) == 0) ? lsfp_pkg::SYNC_BYTE
						: byte_t'($urandom));
			end else begin
				n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
				for (k = 0; k < n; k++)
					send_byte(($urandom_range(0, 5) == 0) ? lsfp_pkg::SYNC_BYTE
						: byte_t'($urandom));
				send_frame(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
					byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
					$urandom_range(0, 4) != 0, byte_t'($urandom_range(1, 255)));
			end
		end
	endtask

	// receiver stall pattern, new mode each time the phase counter wraps
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_phase == '0)
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_phase <= rx_phase + 1'b1;
			case (rx_mode)
				RX_ALWAYS: res_ch.ready <= 1'b1;
				RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: res_ch.ready <= (rx_phase[2:0] == 3'd0);
				default:   res_ch.ready <= (rx_phase[4:0] < 5'd20);
			endcase
		end
	end

	// compare each result beat with the oldest pending expectation
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got_res = '{res_ch.frame_valid, res_ch.range_cm, res_ch.strength,
				res_ch.quality, res_ch.checksum_error, res_ch.overflow_flush};
			if (pending_q.size() == 0) begin
				report_mismatch("result beat with nothing pending", 16'd1, 16'd0);
			end else begin
				want_res = pending_q.pop_front();
				if (got_res.frame_valid != want_res.frame_valid)
					report_mismatch("frame_valid", got_res.frame_valid, want_res.frame_valid);
				if (got_res.range_cm != want_res.range_cm)
					report_mismatch("range_cm", got_res.range_cm, want_res.range_cm);
				if (got_res.strength != want_res.strength)
					report_mismatch("strength", got_res.strength, want_res.strength);
				if (got_res.quality != want_res.quality)
					report_mismatch("quality", got_res.quality, want_res.quality);
				if (got_res.checksum_error != want_res.checksum_error)
					report_mismatch("checksum_error", got_res.checksum_error,
						want_res.checksum_error);
				if (got_res.overflow_flush != want_res.overflow_flush)
					report_mismatch("overflow_flush", got_res.overflow_flush,
						want_res.overflow_flush);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("Verification failed");
			$finish;
		end
	end

	// test sequence
	initial begin
		int i;
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		res_ch.ready      = 1'b0;
		rx_mode           = RX_ALWAYS;
		rx_phase          = '0;
		err_cnt           = 0;
		cycle_cnt         = 0;
		burst_left        = 0;
		bytes_sent        = 0;
		shadow_held       = '0;
		for (i = 0; i < lsfp_pkg::FRAME_LEN; i++)
			shadow_win[i] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_error_at_overflow();
		test_frame_at_overflow_and_resync();
		test_random_traffic();

		byte_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
